FILE: sv/nas_pkg.sv
// ----------------------------------------------------------------------------
// nas_pkg
// shared types, widths and codes for the nearest anchor select unit
// ----------------------------------------------------------------------------
package nas_pkg;

  localparam int COORD_W     = 24;
  localparam int IDX_W       = 8;
  localparam int ARM_W       = 23;
  localparam int CNT_W       = 8;
  localparam int ARM_SQ_W    = 2 * ARM_W;
  localparam int ABS_W       = 24;
  localparam int SQ_W        = 2 * ABS_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int ANCHORS_DEF = 128;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_DATA_W   = IDX_W + 6 * COORD_W;
  localparam int OUT_DATA_W  = 3 * COORD_W + IDX_W;
  localparam int STATUS_W    = 2;

  // last drain count while the distance pipeline empties after the last scan step
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ARM   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT = 1'b1;

  localparam logic [ARM_W-1:0] ARM_RESET   = 23'd4096;
  localparam logic [CNT_W-1:0] COUNT_RESET = 8'd100;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_NEAREST = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FIXED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  localparam logic [IDX_W-1:0] IDX_NONE = 8'hFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } anchor_t;

  typedef struct packed {
    logic init;    // start of a search: load the threshold
    logic sample;  // head of the ring is a candidate
  } dist_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

FILE: sv/nas_cell.sv
// ----------------------------------------------------------------------------
// nas_cell
// one anchor entry of the store ring, loaded directly or shifted from its neighbor
// ----------------------------------------------------------------------------
module nas_cell (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  nas_pkg::anchor_t load_data,
  input  nas_pkg::anchor_t shift_in,
  output nas_pkg::anchor_t value
);
  import nas_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_data;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

FILE: sv/nas_dist.sv
// ----------------------------------------------------------------------------
// nas_dist
// squared distance pipeline with running best entry tracking
// ----------------------------------------------------------------------------
module nas_dist #(
  parameter int IW = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  nas_pkg::dist_ctl_t                ctl,
  input  logic [IW-1:0]                     step,
  input  nas_pkg::anchor_t                  head,
  input  nas_pkg::anchor_t                  pos,
  input  logic [nas_pkg::ARM_SQ_W-1:0]      arm_sq,
  output nas_pkg::anchor_t                  best_anchor,
  output logic [IW-1:0]                     best_idx,
  output logic                              found
);
  import nas_pkg::*;

  logic signed [COORD_W:0] dx, dy, dz;
  logic [ABS_W-1:0] ax1, ay1, az1;
  logic [SQ_W-1:0]  sx2, sy2, sz2;
  logic [DIST_W-1:0] sum3, best;
  logic v1, v2, v3;
  logic [IW-1:0] i1, i2, i3;
  anchor_t a1, a2, a3;

  always_comb begin
    dx = {head.x[COORD_W-1], head.x} - {pos.x[COORD_W-1], pos.x};
    dy = {head.y[COORD_W-1], head.y} - {pos.y[COORD_W-1], pos.y};
    dz = {head.z[COORD_W-1], head.z} - {pos.z[COORD_W-1], pos.z};
  end

  // difference magnitude stays below 2^24, so the sign bit drops out
  always_ff @(posedge clk) begin
    ax1 <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    ay1 <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    az1 <= dz[COORD_W] ? ABS_W'(-dz) : ABS_W'(dz);
    i1  <= step;
    a1  <= head;
    sx2 <= ax1 * ax1;
    sy2 <= ay1 * ay1;
    sz2 <= az1 * az1;
    i2  <= i1;
    a2  <= a1;
    sum3 <= DIST_W'(sx2) + DIST_W'(sy2) + DIST_W'(sz2);
    i3  <= i2;
    a3  <= a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctl.sample;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.init) begin
      found <= 1'b0;
    end else if (v3 && (sum3 < best)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      best <= DIST_W'({arm_sq, 1'b0});
    end else if (v3 && (sum3 < best)) begin
      best        <= sum3;
      best_anchor <= a3;
      best_idx    <= i3;
    end
  end

endmodule

FILE: sv/nearest_anchor_select_unit.sv
// ----------------------------------------------------------------------------
// nearest_anchor_select_unit
// anchor store with fixed lookup and nearest-in-reach search
// ----------------------------------------------------------------------------
// The slave stream takes load items (tuser 0) and query items (tuser 1).
// A load with a non-negative index writes one anchor into its entry and
// returns nothing. A query returns one item on the master stream. The store
// is a ring of cells; every query rotates it once around, one entry a cycle,
// into a three-stage squared distance pipeline, and the unit takes no new item
// while a query is in progress; a load leaves the unit idle. The result sits in
// an output register: a new item is accepted while an earlier result waits, and
// if the receiver still stalls when the next query finishes, the unit holds that
// query until the output register is free. The user writes configuration
// through cfg_we/cfg_index/cfg_wdata only while the unit is idle; the block
// does not enforce this. Reset clears control state and sets configuration to
// its reset values; store entries hold no value until loaded.
// ----------------------------------------------------------------------------
module nearest_anchor_select_unit #(
  parameter int ANCHORS = nas_pkg::ANCHORS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // entry_index, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z
  input  logic [nas_pkg::IN_DATA_W-1:0]      s_tdata,
  // req_type
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // anchor_x, anchor_y, anchor_z, chosen_index
  output logic [nas_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic [nas_pkg::STATUS_W-1:0]       m_tuser,
  input  logic                               cfg_we,
  input  logic [nas_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [nas_pkg::ARM_W-1:0]          cfg_wdata
);
  import nas_pkg::*;

  localparam int IW = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
  localparam int LW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;

  logic [ARM_W-1:0] max_arm_length;
  logic [CNT_W-1:0] anchor_count;

  state_t state, state_next;
  logic [IW-1:0] step;
  logic [1:0] drain_cnt;
  logic q_fixed;
  logic [IDX_W-2:0] q_idx;
  anchor_t q_pos, q_prev, fix_anchor;
  logic [ARM_SQ_W-1:0] arm_sq;

  logic in_fire, load_fire, query_fire, out_free, scan_last, done_fire;
  logic [LW-1:0] limit, in_idx_w, q_idx_w, step_w;
  logic in_neg, load_ok;
  anchor_t in_pos, in_prev;
  dist_ctl_t dctl;
  anchor_t best_anchor;
  logic [IW-1:0] best_idx;
  logic found;

  anchor_t ring [ANCHORS];

  assign in_neg      = s_tdata[IDX_W-1];
  assign in_pos.x    = s_tdata[IDX_W +: COORD_W];
  assign in_pos.y    = s_tdata[IDX_W + COORD_W +: COORD_W];
  assign in_pos.z    = s_tdata[IDX_W + 2*COORD_W +: COORD_W];
  assign in_prev.x   = s_tdata[IDX_W + 3*COORD_W +: COORD_W];
  assign in_prev.y   = s_tdata[IDX_W + 4*COORD_W +: COORD_W];
  assign in_prev.z   = s_tdata[IDX_W + 5*COORD_W +: COORD_W];
  assign in_idx_w    = LW'(s_tdata[IDX_W-2:0]);
  assign q_idx_w     = LW'(q_idx);
  assign step_w      = LW'(step);

  assign limit = (LW'(anchor_count) < LW'(ANCHORS)) ? LW'(anchor_count) : LW'(ANCHORS);

  assign in_fire    = s_tvalid && s_tready;
  assign load_fire  = in_fire && (s_tuser == REQ_LOAD);
  assign query_fire = in_fire && (s_tuser == REQ_QUERY);
  assign load_ok    = load_fire && !in_neg && (in_idx_w < LW'(ANCHORS));
  assign out_free   = !m_tvalid || m_tready;
  assign scan_last  = (step == IW'(ANCHORS - 1));
  assign done_fire  = (state == S_DONE) && out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_arm_length <= ARM_RESET;
      anchor_count   <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ARM:   max_arm_length <= cfg_wdata;
        REG_COUNT: anchor_count   <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // store ring: cell i takes from cell i+1, the head is cell 0
  genvar g;
  generate
    for (g = 0; g < ANCHORS; g++) begin : g_cell
      nas_cell u_cell (
        .clk       (clk),
        .load      (load_ok && (in_idx_w == LW'(g))),
        .shift     (state == S_SCAN),
        .load_data (in_pos),
        .shift_in  (ring[(g + 1) % ANCHORS]),
        .value     (ring[g])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (query_fire) state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_DRAIN;
      S_DRAIN: if (drain_cnt == DRAIN_LAST) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready    = (state == S_IDLE);
    dctl.init   = (state == S_SCAN) && (step == '0);
    dctl.sample = (state == S_SCAN) && !q_fixed && (step_w < limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      drain_cnt <= '0;
    end else begin
      if (state == S_SCAN) begin
        step <= scan_last ? '0 : step + 1'b1;
      end
      if (state == S_DRAIN) begin
        drain_cnt <= drain_cnt + 2'd1;
      end else begin
        drain_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_fire) begin
      q_fixed <= !in_neg;
      q_idx   <= s_tdata[IDX_W-2:0];
      q_pos   <= in_pos;
      q_prev  <= in_prev;
      arm_sq  <= max_arm_length * max_arm_length;
    end
    if ((state == S_SCAN) && q_fixed && (step_w == q_idx_w)) begin
      fix_anchor <= ring[0];
    end
  end

  nas_dist #(
    .IW (IW)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .ctl         (dctl),
    .step        (step),
    .head        (ring[0]),
    .pos         (q_pos),
    .arm_sq      (arm_sq),
    .best_anchor (best_anchor),
    .best_idx    (best_idx),
    .found       (found)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      if (q_fixed) begin
        if (q_idx_w < limit) begin
          m_tdata <= {IDX_NONE, fix_anchor.z, fix_anchor.y, fix_anchor.x};
          m_tuser <= ST_FIXED;
        end else begin
          m_tdata <= {IDX_NONE, q_prev.z, q_prev.y, q_prev.x};
          m_tuser <= ST_RANGE;
        end
      end else if (found) begin
        m_tdata <= {IDX_W'(best_idx), best_anchor.z, best_anchor.y, best_anchor.x};
        m_tuser <= ST_NEAREST;
      end else begin
        m_tdata <= {IDX_NONE, q_prev.z, q_prev.y, q_prev.x};
        m_tuser <= ST_NONE;
      end
    end
  end

endmodule

FILE: sv/nas_checker.sv
// ----------------------------------------------------------------------------
// nas_checker
// port-level checks for the nearest anchor select unit
// ----------------------------------------------------------------------------
module nas_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [nas_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [nas_pkg::STATUS_W-1:0]       m_tuser
);
  import nas_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a query keeps the input side closed while the ring rotates
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_QUERY) |=> !s_tready)
    else $error("input taken during a query");

  // only a search hit carries an index
  a_index_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_NEAREST) |-> m_tdata[OUT_DATA_W-1 -: IDX_W] == IDX_NONE)
    else $error("index set without a search hit");

  a_index_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NEAREST) |-> !m_tdata[OUT_DATA_W-1])
    else $error("search hit with negative index");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind nearest_anchor_select_unit nas_checker u_nas_checker (.*);

FILE: tb/nearest_anchor_select_unit_test.sv
// ----------------------------------------------------------------------------
// nearest_anchor_select_unit_test
// self-checking stream testbench for the nearest anchor select unit
// ----------------------------------------------------------------------------
// Fills the anchor store, runs a short directed set of queries (ties, the reach
// boundary, fixed and out-of-range indices, ignored loads, coordinate extremes)
// and then random loads and queries clustered around stored anchors under
// several reach and count settings. A predictor tracks store and registers and
// every result item is compared field by field. Both stream sides back off at
// random in three idle patterns.
// ----------------------------------------------------------------------------
module nearest_anchor_select_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nas_pkg::*;

  localparam int N_ANCHORS   = ANCHORS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int COORD_MAX   = 8388607;

  localparam logic [IDX_W-1:0] IDX_SEARCH = IDX_NONE;
  localparam logic [IDX_W-1:0] IDX_MOST_NEG = 8'h80;

  typedef struct packed {
    logic                    kind;
    logic signed [IDX_W-1:0] idx;
    anchor_t                 pos;
    anchor_t                 prev;
  } request_t;

  typedef struct packed {
    anchor_t                 anchor;
    logic signed [IDX_W-1:0] chosen;
    logic [STATUS_W-1:0]     status;
  } selection_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [ARM_W-1:0]      cfg_wdata = '0;

  nearest_anchor_select_unit #(
    .ANCHORS(N_ANCHORS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  request_t   request_q[$];
  selection_t selection_q[$];
  request_t   cur_req;

  // predictor copy of the store, updated on accept, and of the registers
  anchor_t     model_store[N_ANCHORS];
  int          reach = int'(ARM_RESET);
  int          count_in_use = int'(COUNT_RESET);
  // store contents as the generator has planned them so far
  anchor_t     plan_store[N_ANCHORS];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          n_loads = 0;
  int          n_queries = 0;
  int          n_checked = 0;
  int          status_seen[4] = '{0, 0, 0, 0};
  int          stall_cycles = 0;

  function automatic longint dist2(anchor_t a, anchor_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic void predict_selection(request_t r);
    selection_t res;
    longint     best, d;
    int         lim;
    if (r.kind == REQ_LOAD) begin
      n_loads++;
      if (!r.idx[IDX_W-1]) model_store[r.idx[6:0]] = r.pos;
      return;
    end
    n_queries++;
    res.anchor = r.prev;
    res.chosen = IDX_NONE;
    lim = (count_in_use < N_ANCHORS) ? count_in_use : N_ANCHORS;
    if (!r.idx[IDX_W-1]) begin
      if (int'(r.idx) < lim) begin
        res.anchor = model_store[r.idx[6:0]];
        res.status = ST_FIXED;
      end else begin
        res.status = ST_RANGE;
      end
    end else begin
      best = longint'(reach) * longint'(reach) * 2;
      res.status = ST_NONE;
      for (int i = 0; i < lim; i++) begin
        d = dist2(model_store[i], r.pos);
        // strict compare keeps the lowest index on a tie
        if (d < best) begin
          best = d;
          res.anchor = model_store[i];
          res.chosen = i[IDX_W-1:0];
          res.status = ST_NEAREST;
        end
      end
    end
    selection_q.push_back(res);
  endfunction

  function automatic void cmp_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_selection();
    selection_t want, got;
    got.anchor = m_tdata[3*COORD_W-1:0];
    got.chosen = m_tdata[OUT_DATA_W-1:3*COORD_W];
    got.status = m_tuser;
    if (selection_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result expected none actual %h/%h", $time, m_tdata, m_tuser);
      return;
    end
    want = selection_q.pop_front();
    n_checked++;
    status_seen[want.status]++;
    cmp_field("anchor_x", want.anchor.x, got.anchor.x);
    cmp_field("anchor_y", want.anchor.y, got.anchor.y);
    cmp_field("anchor_z", want.anchor.z, got.anchor.z);
    cmp_field("chosen_index", {16'b0, want.chosen}, {16'b0, got.chosen});
    cmp_field("status", {22'b0, want.status}, {22'b0, got.status});
  endfunction

  // sender side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_selection(cur_req);
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.prev, cur_req.pos, cur_req.idx};
          s_tuser  <= cur_req.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_selection();
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic anchor_t pt(int x, int y, int z);
    anchor_t p;
    p.x = x[23:0];
    p.y = y[23:0];
    p.z = z[23:0];
    return p;
  endfunction

  function automatic anchor_t rand_point();
    anchor_t     p;
    logic [31:0] r;
    r = $urandom();
    p.x = r[23:0];
    r = $urandom();
    p.y = r[23:0];
    r = $urandom();
    p.z = r[23:0];
    return p;
  endfunction

  function automatic anchor_t jitter(anchor_t c, int spread);
    anchor_t     p;
    logic [31:0] o;
    o = $urandom_range(2 * spread) - spread;
    p.x = c.x + o[23:0];
    o = $urandom_range(2 * spread) - spread;
    p.y = c.y + o[23:0];
    o = $urandom_range(2 * spread) - spread;
    p.z = c.z + o[23:0];
    return p;
  endfunction

  function automatic logic [IDX_W-1:0] rand_negative();
    logic [31:0] r;
    r = $urandom();
    return {1'b1, r[6:0]};
  endfunction

  function automatic void push_load(logic [IDX_W-1:0] idx, anchor_t p);
    request_t r;
    r.kind = REQ_LOAD;
    r.idx  = idx;
    r.pos  = p;
    r.prev = rand_point();
    if (!idx[IDX_W-1]) plan_store[idx[6:0]] = p;
    request_q.push_back(r);
  endfunction

  function automatic void push_query(logic [IDX_W-1:0] idx, anchor_t p, anchor_t prev);
    request_t r;
    r.kind = REQ_QUERY;
    r.idx  = idx;
    r.pos  = p;
    r.prev = prev;
    request_q.push_back(r);
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || s_tvalid || selection_q.size() != 0) @(posedge clk);
    // a trailing load can still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int arm, int cnt);
    logic [31:0] a, c;
    a = arm;
    c = cnt;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ARM;
    cfg_wdata <= a[ARM_W-1:0];
    @(posedge clk);
    cfg_index <= REG_COUNT;
    cfg_wdata <= {15'b0, c[CNT_W-1:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    reach = arm;
    count_in_use = cnt;
  endtask

  function automatic void gen_random(int n);
    int      roll, sub, lim, sp;
    anchor_t base;
    lim = (count_in_use < N_ANCHORS) ? count_in_use : N_ANCHORS;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      sub  = $urandom_range(99);
      case ($urandom_range(2))
        0:       sp = reach / 4;
        1:       sp = reach;
        default: sp = reach * 2;
      endcase
      if (sp > COORD_MAX) sp = COORD_MAX;
      base = plan_store[$urandom_range(lim - 1)];
      if (roll < 22) begin
        if (sub < 10) push_load(rand_negative(), rand_point());
        else if (sub < 30) push_load(7'($urandom_range(N_ANCHORS - 1)), base);
        else if (sub < 65) push_load(7'($urandom_range(N_ANCHORS - 1)), jitter(base, sp));
        else push_load(7'($urandom_range(N_ANCHORS - 1)), rand_point());
      end else begin
        if (sub < 48) push_query(IDX_SEARCH, jitter(base, sp), rand_point());
        else if (sub < 55) push_query(rand_negative(), jitter(base, sp), rand_point());
        else if (sub < 62) push_query(IDX_SEARCH, base, rand_point());
        else if (sub < 87) push_query(7'($urandom_range(N_ANCHORS - 1)), rand_point(),
                                      rand_point());
        else push_query(IDX_SEARCH, rand_point(), rand_point());
      end
    end
  endfunction

  task automatic run_phase(int arm, int cnt, int send_pct, int recv_pct, int n);
    wait_drained();
    set_config(arm, cnt);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    gen_random(n);
  endtask

  initial begin
    anchor_t a_pt, b_pt, c_pt, d_pt, hi_pt, lo_pt, edge_prev;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 72;

    // every entry is written before any query reads it
    for (int i = 0; i < N_ANCHORS; i++) push_load(i[IDX_W-1:0], rand_point());

    a_pt      = pt(1000, -2000, 3000);
    b_pt      = pt(-500000, 700000, -900000);
    c_pt      = pt(2222222, 0, -3333333);
    d_pt      = pt(-2222222, 5000000, 123456);
    hi_pt     = pt(COORD_MAX, COORD_MAX, COORD_MAX);
    lo_pt     = pt(-COORD_MAX - 1, -COORD_MAX - 1, -COORD_MAX - 1);
    edge_prev = pt(-COORD_MAX - 1, COORD_MAX, 0);

    // tie between two identical entries, lowest index wins
    push_load(8'd5, a_pt);
    push_load(8'd9, a_pt);
    push_query(IDX_SEARCH, a_pt, edge_prev);
    // exactly on the reach boundary is out, one step inside is in
    push_query(IDX_SEARCH, pt(1000 + 4096, -2000 + 4096, 3000), edge_prev);
    push_query(IDX_SEARCH, pt(1000 + 4096, -2000 + 4095, 3000), rand_point());
    push_query(IDX_MOST_NEG, a_pt, rand_point());
    // fixed lookups at and past the count
    push_query(8'd0, rand_point(), rand_point());
    push_query(8'd99, rand_point(), rand_point());
    push_query(8'd100, rand_point(), edge_prev);
    push_query(8'd127, lo_pt, hi_pt);
    push_load(8'd7, hi_pt);
    push_load(8'd12, lo_pt);
    push_query(IDX_SEARCH, hi_pt, lo_pt);
    push_query(IDX_SEARCH, lo_pt, hi_pt);
    // loads with a negative index leave the store alone
    push_load(IDX_NONE, b_pt);
    push_load(IDX_MOST_NEG, b_pt);
    push_query(IDX_SEARCH, b_pt, edge_prev);
    // last entry in use, and one just beyond the count
    push_load(8'd99, c_pt);
    push_query(IDX_SEARCH, c_pt, rand_point());
    push_load(8'd100, d_pt);
    push_query(IDX_SEARCH, d_pt, rand_point());

    run_phase(16384, 128, 19, 72, 180);
    run_phase(0, 1, 19, 72, 80);
    run_phase(COORD_MAX, 128, 72, 19, 180);
    run_phase(int'($urandom_range(65535, 1)), int'($urandom_range(128, 1)), 72, 19, 180);
    run_phase(1, 64, 0, 0, 150);
    run_phase(int'($urandom_range(65535, 1)), int'($urandom_range(128, 1)), 0, 0, 180);
    run_phase(int'($urandom_range(COORD_MAX, 0)), int'($urandom_range(128, 1)), 0, 0, 100);

    wait_drained();
    repeat (N_ANCHORS + 10) @(posedge clk);
    if (selection_q.size() != 0) begin
      mismatches++;
      $display("%0t: results missing expected %0d actual 0", $time, selection_q.size());
    end
    $display("covered %0d loads and %0d queries over eight register settings, three idle modes",
             n_loads, n_queries);
    $display("checked %0d results: nearest %0d, fixed %0d, none in reach %0d, out of range %0d",
             n_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
